// ===== rtl/aesp_pkg.sv =====
// Shared types and constants for the ANSI escape sequence parser.
package aesp_pkg;

  typedef logic [2:0] kind_t;

  // Event kinds
  localparam kind_t EV_RESET    = 3'd0;
  localparam kind_t EV_CLEAR    = 3'd1;
  localparam kind_t EV_POS      = 3'd2;
  localparam kind_t EV_BOLD_ON  = 3'd3;
  localparam kind_t EV_BOLD_OFF = 3'd4;
  localparam kind_t EV_COLOUR   = 3'd5;
  localparam kind_t EV_UNKNOWN  = 3'd6;

  // Parser modes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ESCAPE = 2'd1;
  localparam logic [1:0] MODE_CSI    = 2'd2;
  localparam logic [1:0] MODE_OSC    = 2'd3;

  // Buffer classes
  localparam logic [1:0] CLASS_EMPTY = 2'd0;
  localparam logic [1:0] CLASS_ZERO  = 2'd1;
  localparam logic [1:0] CLASS_OTHER = 2'd2;

  // Byte codes
  localparam logic [7:0] CH_BEL     = 8'h07;
  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_LOWER_C = 8'h63;
  localparam logic [7:0] CH_H       = 8'h48;
  localparam logic [7:0] CH_J       = 8'h4A;
  localparam logic [7:0] CH_M       = 8'h6D;
  localparam logic [7:0] FINAL_LO   = 8'h40;
  localparam logic [7:0] FINAL_HI   = 8'h7E;

  // Attribute codes
  localparam logic [15:0] ATTR_RESET    = 16'd0;
  localparam logic [15:0] ATTR_BOLD     = 16'd1;
  localparam logic [15:0] ATTR_NORMAL   = 16'd22;
  localparam logic [15:0] ATTR_COLOUR_LO = 16'd30;
  localparam logic [15:0] ATTR_COLOUR_HI = 16'd37;

  localparam logic [15:0] VALUE_MAX   = 16'hFFFF;
  localparam logic [4:0]  EVENT_LIMIT = 5'd16;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] row;
    logic [15:0] col;
    logic [2:0]  colour;
    logic [7:0]  fb;
  } event_t;

endpackage

// ===== rtl/ansi_escape_sequence_parser_top.sv =====
// Top level of the ANSI / VT100 escape sequence parser.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------
//  in      | sink      | in_valid/in_stall  | data_byte
//  out     | source    | out_valid/out_stall| event_kind, cursor_row, cursor_col,
//          |           |                    | colour_index, final_byte, last_event
//
// Ordinary bytes are accepted while the sequencer is idle and the output is free. A CSI
// 'm' or 'H' final byte starts a walk over the parameter RAM: 'm' reads every stored
// parameter, 'H' only the first one or two. Each read passes ISSUE then DATA (registered
// RAM read), and FLUSH emits the last event. ESC c emits its three events in turn.
// Reset (synchronous, rst high) clears all control state; the parameter RAM is not
// cleared, only entries below the parameter count are ever read.
// A stalled output holds its event, and holds off the input; further events wait in a
// one-entry hold register.
module ansi_escape_sequence_parser_top #(
  parameter int MAX_PARAMS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           data_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output aesp_pkg::kind_t      event_kind,
  output logic [15:0]          cursor_row,
  output logic [15:0]          cursor_col,
  output logic [2:0]           colour_index,
  output logic [7:0]           final_byte,
  output logic                 last_event
);
  import aesp_pkg::*;

  localparam int AW = $clog2(MAX_PARAMS > 1 ? MAX_PARAMS : 2);
  localparam int CW = $clog2(MAX_PARAMS + 1);
  localparam logic [CW-1:0] MAXP = CW'(MAX_PARAMS);

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ESCRST = 3'd1;
  localparam logic [2:0] ST_ISSUE  = 3'd2;
  localparam logic [2:0] ST_DATA   = 3'd3;
  localparam logic [2:0] ST_FLUSH  = 3'd4;

  logic [2:0]    state;
  logic [1:0]    mode;
  logic [CW-1:0] count;
  logic [15:0]   cur_val;
  logic          cur_inv;
  logic [1:0]    bclass;
  logic [CW-1:0] total;
  logic [CW-1:0] idx;
  logic          is_pos;
  logic          rst_step;
  logic          hold_valid;
  event_t        hold;
  logic [4:0]    ev_cnt;

  logic          out_free;
  logic          take;
  logic          is_final;
  logic          is_digit;
  logic [3:0]    digit;
  logic [19:0]   prod;
  logic          can_commit;
  logic [15:0]   commit_val;
  logic          ram_we;
  logic          ram_re;
  logic [15:0]   rdata;
  logic [CW-1:0] idx_inc;

  // attribute decode of the word just read
  logic          m_hit;
  kind_t         m_kind;
  logic [2:0]    m_diff;
  logic          rec;
  logic          blocked;

  // output load
  logic          load_en;
  event_t        load_ev;
  logic          load_last;

  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = !((state == ST_IDLE) && out_free);
  assign take       = in_valid && !in_stall;
  assign is_final   = data_byte inside {[FINAL_LO:FINAL_HI]};
  assign is_digit   = data_byte inside {[CH_0:CH_9]};
  // low nibble of an ASCII digit is its value
  assign digit      = data_byte[3:0];
  // value * 10 + digit, by shifts
  assign prod       = (20'(cur_val) << 3) + (20'(cur_val) << 1) + 20'(digit);
  assign can_commit = count < MAXP;
  assign commit_val = cur_inv ? 16'd0 : cur_val;
  assign idx_inc    = idx + CW'(1);

  assign ram_we = take && (mode == MODE_CSI) && (is_final || data_byte == CH_SEMI)
                  && can_commit;
  assign ram_re = (state == ST_ISSUE);

  aesp_ram #(
    .WIDTH (16),
    .DEPTH (MAX_PARAMS)
  ) u_param_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (commit_val),
    .re    (ram_re),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  assign m_diff = 3'(rdata - ATTR_COLOUR_LO);

  always_comb begin
    m_hit  = 1'b1;
    m_kind = EV_RESET;
    if (rdata == ATTR_RESET) begin
      m_kind = EV_RESET;
    end else if (rdata == ATTR_BOLD) begin
      m_kind = EV_BOLD_ON;
    end else if (rdata == ATTR_NORMAL) begin
      m_kind = EV_BOLD_OFF;
    end else if (rdata >= ATTR_COLOUR_LO && rdata <= ATTR_COLOUR_HI) begin
      m_kind = EV_COLOUR;
    end else begin
      m_hit  = 1'b0;
    end
  end

  // an attribute event is recorded only below the per-byte event limit
  assign rec     = !is_pos && m_hit && (ev_cnt < EVENT_LIMIT);
  assign blocked = rec && hold_valid && !out_free;

  // What goes into the output register this cycle
  always_comb begin
    load_en   = 1'b0;
    load_ev   = '0;
    load_last = 1'b0;
    case (state)
      ST_IDLE: begin
        if (take && mode == MODE_ESCAPE && data_byte == CH_LOWER_C) begin
          load_en      = 1'b1;
          load_ev.kind = EV_RESET;
        end else if (take && mode == MODE_CSI && is_final) begin
          if (data_byte == CH_J) begin
            if (bclass != CLASS_OTHER) begin
              load_en      = 1'b1;
              load_ev.kind = EV_CLEAR;
              load_last    = 1'b1;
            end
          end else if (data_byte != CH_H && data_byte != CH_M) begin
            load_en      = 1'b1;
            load_ev.kind = EV_UNKNOWN;
            load_ev.fb   = data_byte;
            load_last    = 1'b1;
          end
        end
      end
      ST_ESCRST: begin
        if (out_free) begin
          load_en = 1'b1;
          if (rst_step) begin
            load_ev.kind = EV_POS;
            load_ev.row  = 16'd1;
            load_ev.col  = 16'd1;
            load_last    = 1'b1;
          end else begin
            load_ev.kind = EV_CLEAR;
          end
        end
      end
      ST_DATA: begin
        if (rec && hold_valid && out_free) begin
          load_en = 1'b1;
          load_ev = hold;
        end
      end
      ST_FLUSH: begin
        if (hold_valid && out_free) begin
          load_en   = 1'b1;
          load_ev   = hold;
          load_last = 1'b1;
        end
      end
      default: begin
        load_en = 1'b0;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      event_kind   <= load_ev.kind;
      cursor_row   <= load_ev.row;
      cursor_col   <= load_ev.col;
      colour_index <= load_ev.colour;
      final_byte   <= load_ev.fb;
      last_event   <= load_last;
    end
  end

  // Parser and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      mode       <= MODE_NORMAL;
      count      <= '0;
      cur_val    <= '0;
      cur_inv    <= 1'b0;
      bclass     <= CLASS_EMPTY;
      total      <= '0;
      idx        <= '0;
      is_pos     <= 1'b0;
      rst_step   <= 1'b0;
      hold_valid <= 1'b0;
      ev_cnt     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (take) begin
            case (mode)
              MODE_NORMAL: begin
                if (data_byte == CH_ESC) begin
                  mode    <= MODE_ESCAPE;
                  count   <= '0;
                  cur_val <= '0;
                  cur_inv <= 1'b0;
                  bclass  <= CLASS_EMPTY;
                end
              end
              MODE_ESCAPE: begin
                if (data_byte == CH_LBRACK) begin
                  mode    <= MODE_CSI;
                  count   <= '0;
                  cur_val <= '0;
                  cur_inv <= 1'b0;
                  bclass  <= CLASS_EMPTY;
                end else if (data_byte == CH_RBRACK) begin
                  mode <= MODE_OSC;
                end else begin
                  if (data_byte == CH_LOWER_C) begin
                    count    <= '0;
                    cur_val  <= '0;
                    cur_inv  <= 1'b0;
                    bclass   <= CLASS_EMPTY;
                    rst_step <= 1'b0;
                    state    <= ST_ESCRST;
                  end
                  mode <= MODE_NORMAL;
                end
              end
              MODE_CSI: begin
                if (is_final) begin
                  // final commit, then the walk reads what was stored
                  total   <= can_commit ? count + CW'(1) : count;
                  mode    <= MODE_NORMAL;
                  count   <= '0;
                  cur_val <= '0;
                  cur_inv <= 1'b0;
                  bclass  <= CLASS_EMPTY;
                  if (data_byte == CH_H || data_byte == CH_M) begin
                    idx        <= '0;
                    is_pos     <= (data_byte == CH_H);
                    ev_cnt     <= '0;
                    hold_valid <= 1'b0;
                    state      <= ST_ISSUE;
                  end
                end else begin
                  if (bclass == CLASS_EMPTY && data_byte == CH_0) begin
                    bclass <= CLASS_ZERO;
                  end else begin
                    bclass <= CLASS_OTHER;
                  end
                  if (data_byte == CH_SEMI) begin
                    if (can_commit) begin
                      count <= count + CW'(1);
                    end
                    cur_val <= '0;
                    cur_inv <= 1'b0;
                  end else if (is_digit) begin
                    if (!cur_inv) begin
                      if (prod > 20'(VALUE_MAX)) begin
                        cur_inv <= 1'b1;
                        cur_val <= '0;
                      end else begin
                        cur_val <= prod[15:0];
                      end
                    end
                  end else begin
                    cur_inv <= 1'b1;
                  end
                end
              end
              default: begin
                // OSC: swallow until BEL or ESC
                if (data_byte == CH_BEL || data_byte == CH_ESC) begin
                  mode    <= MODE_NORMAL;
                  count   <= '0;
                  cur_val <= '0;
                  cur_inv <= 1'b0;
                  bclass  <= CLASS_EMPTY;
                end
              end
            endcase
          end
        end
        ST_ESCRST: begin
          if (out_free) begin
            if (rst_step) begin
              state <= ST_IDLE;
            end
            rst_step <= 1'b1;
          end
        end
        ST_ISSUE: begin
          state <= ST_DATA;
        end
        ST_DATA: begin
          if (is_pos) begin
            if (idx == '0) begin
              hold.kind   <= EV_POS;
              hold.row    <= rdata;
              hold.colour <= '0;
              hold.fb     <= '0;
              if (total >= CW'(2)) begin
                idx   <= idx_inc;
                state <= ST_ISSUE;
              end else begin
                hold.col   <= 16'd1;
                hold_valid <= 1'b1;
                state      <= ST_FLUSH;
              end
            end else begin
              hold.col   <= rdata;
              hold_valid <= 1'b1;
              state      <= ST_FLUSH;
            end
          end else if (!blocked) begin
            if (rec) begin
              hold.kind   <= m_kind;
              hold.row    <= '0;
              hold.col    <= '0;
              hold.colour <= (m_kind == EV_COLOUR) ? m_diff : 3'd0;
              hold.fb     <= '0;
              hold_valid  <= 1'b1;
              ev_cnt      <= ev_cnt + 5'd1;
            end
            idx <= idx_inc;
            if (idx_inc == total) begin
              state <= ST_FLUSH;
            end else begin
              state <= ST_ISSUE;
            end
          end
        end
        ST_FLUSH: begin
          if (!hold_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            hold_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/aesp_ram.sv =====
// Generic single-port-write, registered-read RAM.
module aesp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/aesp_check.sv =====
// Port-level checker for the escape sequence parser, bound to the top level.
module aesp_check (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_stall,
  input aesp_pkg::kind_t event_kind,
  input logic [15:0]     cursor_row,
  input logic [15:0]     cursor_col,
  input logic [2:0]      colour_index,
  input logic [7:0]      final_byte,
  input logic            last_event
);
  import aesp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_kind) && $stable(last_event)
      && $stable(cursor_row) && $stable(cursor_col))
    else $error("stalled event changed");

  a_pos_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != EV_POS |-> cursor_row == 16'd0 && cursor_col == 16'd0)
    else $error("cursor fields set on a non-position event");

  a_colour_field: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != EV_COLOUR |-> colour_index == 3'd0)
    else $error("colour set on a non-colour event");

  a_unknown: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == EV_UNKNOWN |-> last_event && final_byte >= FINAL_LO
      && final_byte <= FINAL_HI && final_byte != CH_H && final_byte != CH_M)
    else $error("bad unknown-sequence event");

  a_fb_field: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != EV_UNKNOWN |-> final_byte == 8'd0)
    else $error("final byte set on a known event");

endmodule

bind ansi_escape_sequence_parser_top aesp_check u_aesp_check (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .event_kind   (event_kind),
  .cursor_row   (cursor_row),
  .cursor_col   (cursor_col),
  .colour_index (colour_index),
  .final_byte   (final_byte),
  .last_event   (last_event)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for the ANSI escape sequence parser.
`timescale 1ns / 1ps

module testbench;
  import aesp_pkg::*;

  localparam int PARAM_SLOTS    = 16;    // matches the parser's MAX_PARAMS
  localparam int DRAIN_CYCLES   = 64;    // margin for the longest parameter walk, over all 16 slots
  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no transfer on either side
  localparam int FIRST_HALF     = 240;
  localparam int ITEM_TARGET    = 480;

  // One expected event, as it should appear on the output ports
  typedef struct packed {
    kind_t       kind;
    logic [15:0] row;
    logic [15:0] col;
    logic [2:0]  colour;
    logic [7:0]  fb;
    logic        last;
  } term_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  kind_t       event_kind;
  logic [15:0] cursor_row;
  logic [15:0] cursor_col;
  logic [2:0]  colour_index;
  logic [7:0]  final_byte;
  logic        last_event;

  logic [7:0]  byte_queue[$];      // bytes still to be offered to the parser
  term_event_t pending_events[$];  // events predicted but not yet seen
  term_event_t step_events[$];     // events caused by the byte being decoded
  term_event_t head_event;
  int          error_count = 0;
  int          item_total = 0;
  int          cycle_no = 0;
  int          quiet_cycles = 0;
  logic        calm;

  // Shadow copy of the parser state
  logic [1:0]  sh_mode;
  logic [15:0] sh_params[PARAM_SLOTS];
  int          sh_count;
  logic [31:0] sh_value;
  logic        sh_void;
  logic [1:0]  sh_class;

  always #6 clk = ~clk;

  ansi_escape_sequence_parser_top #(.MAX_PARAMS(PARAM_SLOTS)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .event_kind(event_kind),
    .cursor_row(cursor_row),
    .cursor_col(cursor_col),
    .colour_index(colour_index),
    .final_byte(final_byte),
    .last_event(last_event)
  );

  // ---------------------------------------------------------------------------
  // Predictor of the parser
  // ---------------------------------------------------------------------------

  function automatic void add_event(kind_t k, logic [15:0] r, logic [15:0] c,
                                    logic [2:0] colour, logic [7:0] f);
    term_event_t e;
    e.kind   = k;
    e.row    = r;
    e.col    = c;
    e.colour = colour;
    e.fb     = f;
    e.last   = 1'b0;
    // at most EVENT_LIMIT events per byte, the rest are dropped
    if (step_events.size() < EVENT_LIMIT) step_events.push_back(e);
  endfunction

  function automatic void clear_params();
    sh_count = 0;
    sh_value = 0;
    sh_void  = 1'b0;
    sh_class = CLASS_EMPTY;
  endfunction

  function automatic void commit_param();
    if (sh_count < PARAM_SLOTS) begin
      sh_params[sh_count] = sh_void ? 16'd0 : sh_value[15:0];
      sh_count++;
    end
    sh_value = 0;
    sh_void  = 1'b0;
  endfunction

  function automatic void collect_param_byte(logic [7:0] b);
    if (sh_class == CLASS_EMPTY && b == CH_0) sh_class = CLASS_ZERO;
    else sh_class = CLASS_OTHER;
    if (b == CH_SEMI) begin
      commit_param();
    end else if (b >= CH_0 && b <= CH_9) begin
      if (!sh_void) begin
        sh_value = sh_value * 10 + (b - CH_0);
        // out-of-range value voids the parameter
        if (sh_value > VALUE_MAX) begin
          sh_void  = 1'b1;
          sh_value = 0;
        end
      end
    end else begin
      sh_void = 1'b1;
    end
  endfunction

  function automatic void finish_csi(logic [7:0] fb);
    logic [1:0]  cls;
    logic [15:0] v;
    cls = sh_class;
    commit_param();
    if (fb == CH_H) begin
      // absent column defaults to 1; empty fields have already become 0
      add_event(EV_POS, sh_params[0], (sh_count >= 2) ? sh_params[1] : 16'd1, 3'd0, 8'd0);
    end else if (fb == CH_J) begin
      if (cls == CLASS_EMPTY || cls == CLASS_ZERO)
        add_event(EV_CLEAR, 16'd0, 16'd0, 3'd0, 8'd0);
    end else if (fb == CH_M) begin
      for (int i = 0; i < sh_count; i++) begin
        v = sh_params[i];
        if (v == ATTR_RESET) add_event(EV_RESET, 16'd0, 16'd0, 3'd0, 8'd0);
        else if (v == ATTR_BOLD) add_event(EV_BOLD_ON, 16'd0, 16'd0, 3'd0, 8'd0);
        else if (v == ATTR_NORMAL) add_event(EV_BOLD_OFF, 16'd0, 16'd0, 3'd0, 8'd0);
        else if (v >= ATTR_COLOUR_LO && v <= ATTR_COLOUR_HI)
          add_event(EV_COLOUR, 16'd0, 16'd0, 3'(v - ATTR_COLOUR_LO), 8'd0);
      end
    end else begin
      add_event(EV_UNKNOWN, 16'd0, 16'd0, 3'd0, fb);
    end
    clear_params();
    sh_mode = MODE_NORMAL;
  endfunction

  // Decode one accepted byte and queue the events it should cause
  function automatic void decode_term_byte(logic [7:0] b);
    term_event_t e;
    step_events.delete();
    case (sh_mode)
      MODE_NORMAL: begin
        if (b == CH_ESC) begin
          sh_mode = MODE_ESCAPE;
          clear_params();
        end
      end
      MODE_ESCAPE: begin
        if (b == CH_LBRACK) begin
          sh_mode = MODE_CSI;
          clear_params();
        end else if (b == CH_RBRACK) begin
          sh_mode = MODE_OSC;
        end else begin
          if (b == CH_LOWER_C) begin
            clear_params();
            add_event(EV_RESET, 16'd0, 16'd0, 3'd0, 8'd0);
            add_event(EV_CLEAR, 16'd0, 16'd0, 3'd0, 8'd0);
            add_event(EV_POS, 16'd1, 16'd1, 3'd0, 8'd0);
          end
          sh_mode = MODE_NORMAL;
        end
      end
      MODE_CSI: begin
        if (b >= FINAL_LO && b <= FINAL_HI) finish_csi(b);
        else collect_param_byte(b);
      end
      default: begin
        if (b == CH_BEL || b == CH_ESC) begin
          sh_mode = MODE_NORMAL;
          clear_params();
        end
      end
    endcase
    for (int i = 0; i < step_events.size(); i++) begin
      e = step_events[i];
      e.last = (i == step_events.size() - 1);
      pending_events.push_back(e);
    end
  endfunction

  function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      error_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued bytes, holding each until its transfer
  // ---------------------------------------------------------------------------

  // stretch of the run with no idling on either side
  assign calm = (cycle_no >= 300 && cycle_no < 550);

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (byte_queue.size() != 0 && (calm || $urandom_range(99) >= 28)) begin
        in_valid  <= 1'b1;
        data_byte <= byte_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on input transfers, checks output transfers, drives stall
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      sh_mode = MODE_NORMAL;
      clear_params();
    end else begin
      // predict first, so a same-cycle result would already have its expectation
      if (in_valid && !in_stall) decode_term_byte(data_byte);
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected event, expected none, actual kind %0d", $time, event_kind);
          error_count++;
        end else begin
          head_event = pending_events.pop_front();
          check_field("event_kind", 16'(head_event.kind), 16'(event_kind));
          check_field("cursor_row", head_event.row, cursor_row);
          check_field("cursor_col", head_event.col, cursor_col);
          check_field("colour_index", 16'(head_event.colour), 16'(colour_index));
          check_field("final_byte", 16'(head_event.fb), 16'(final_byte));
          check_field("last_event", 16'(head_event.last), 16'(last_event));
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 28);
    end
  end

  // Watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic push_byte(logic [7:0] b, bit counted);
    byte_queue.push_back(b);
    if (counted) item_total++;
  endtask

  task automatic push_number(int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b1);
  endtask

  // a byte that is neither a digit, ';' nor a CSI final byte
  function automatic logic [7:0] pick_junk();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while ((b >= FINAL_LO && b <= FINAL_HI) || (b >= CH_0 && b <= CH_9) || b == CH_SEMI);
    return b;
  endfunction

  task automatic push_param();
    int pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      // empty parameter
    end else if (pick < 50) begin
      case ($urandom_range(5))
        0: push_number(32'(ATTR_RESET));
        1: push_number(32'(ATTR_BOLD));
        2: push_number(32'(ATTR_NORMAL));
        3: push_number($urandom_range(29, 39));
        default: push_number($urandom_range(ATTR_COLOUR_LO, ATTR_COLOUR_HI));
      endcase
    end else if (pick < 72) begin
      push_number($urandom_range(300));
    end else if (pick < 82) begin
      // around the top of the 16-bit range and beyond
      if ($urandom_range(1)) push_number($urandom_range(65530, 65540));
      else push_number($urandom_range(65536, 999999));
    end else if (pick < 88) begin
      push_byte(CH_0, 1'b1);
      push_number($urandom_range(40));
    end else begin
      // parameter spoilt by a stray byte
      if ($urandom_range(1)) push_number($urandom_range(99));
      push_byte(pick_junk(), 1'b1);
      if ($urandom_range(1)) push_number($urandom_range(99));
    end
  endtask

  task automatic push_csi();
    int          n;
    int          pick;
    logic [7:0]  fb;
    pick = $urandom_range(99);
    if (pick < 35) fb = CH_M;
    else if (pick < 60) fb = CH_H;
    else if (pick < 75) fb = CH_J;
    else fb = 8'($urandom_range(FINAL_LO, FINAL_HI));
    pick = $urandom_range(99);
    if (pick < 80) n = $urandom_range(4);
    else if (pick < 95) n = $urandom_range(5, 10);
    else n = $urandom_range(14, 18);   // around and past the parameter store
    push_byte(CH_ESC, 1'b1);
    push_byte(CH_LBRACK, 1'b1);
    if (fb == CH_J && $urandom_range(1)) begin
      // clear variants: empty, "0", and near misses
      case ($urandom_range(4))
        0: ;
        1: push_byte(CH_0, 1'b1);
        2: begin push_byte(CH_0, 1'b1); push_byte(CH_0, 1'b1); end
        3: push_byte(CH_SEMI, 1'b1);
        default: push_number($urandom_range(1, 3));
      endcase
    end else begin
      for (int i = 0; i < n; i++) begin
        if (i != 0) push_byte(CH_SEMI, 1'b1);
        push_param();
      end
    end
    push_byte(fb, 1'b1);
  endtask

  task automatic push_osc();
    logic [7:0] b;
    push_byte(CH_ESC, 1'b1);
    push_byte(CH_RBRACK, 1'b1);
    repeat ($urandom_range(6)) begin
      do b = 8'($urandom_range(255));
      while (b == CH_BEL || b == CH_ESC);
      push_byte(b, 1'b1);
    end
    push_byte($urandom_range(1) ? CH_BEL : CH_ESC, 1'b1);
  endtask

  task automatic push_random_until(int target);
    int         pick;
    logic [7:0] b;
    while (item_total < target) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        push_csi();
      end else if (pick < 60) begin
        push_byte(CH_ESC, 1'b1);
        push_byte(CH_LOWER_C, 1'b1);
      end else if (pick < 70) begin
        push_osc();
      end else if (pick < 78) begin
        // escape followed by something that is not a sequence introducer
        do b = 8'($urandom_range(255));
        while (b == CH_LBRACK || b == CH_RBRACK || b == CH_LOWER_C);
        push_byte(CH_ESC, 1'b1);
        push_byte(b, 1'b1);
      end else begin
        // plain text, mostly ignored; a stray ESC here breaks the next sequence
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)), 1'b1);
      end
    end
  endtask

  // Hold the sender back until every predicted event has been seen
  task automatic wait_until_drained();
    @(negedge clk);
    while (byte_queue.size() != 0 || in_valid || pending_events.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    // directed: escape reset, empty cursor fields, attribute walk, clear,
    // OSC with BEL, escape then escape, unknown final byte
    push_byte(CH_ESC, 1'b1); push_byte(CH_LOWER_C, 1'b1);
    push_byte(CH_ESC, 1'b1); push_byte(CH_LBRACK, 1'b1);
    push_byte(CH_SEMI, 1'b1); push_byte(CH_H, 1'b1);
    push_byte(CH_ESC, 1'b1); push_byte(CH_LBRACK, 1'b1);
    push_number(32'(ATTR_BOLD)); push_byte(CH_SEMI, 1'b1);
    push_number(32'(ATTR_NORMAL)); push_byte(CH_SEMI, 1'b1);
    push_number(32'(ATTR_COLOUR_HI)); push_byte(CH_M, 1'b1);
    push_byte(CH_ESC, 1'b1); push_byte(CH_LBRACK, 1'b1); push_byte(CH_J, 1'b1);
    push_byte(CH_ESC, 1'b1); push_byte(CH_RBRACK, 1'b1);
    push_byte(8'h41, 1'b1); push_byte(CH_BEL, 1'b1);
    push_byte(CH_ESC, 1'b1); push_byte(CH_ESC, 1'b1);
    push_byte(CH_ESC, 1'b1); push_byte(CH_LBRACK, 1'b1); push_byte(FINAL_HI, 1'b1);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    wait_until_drained();
    push_random_until(FIRST_HALF);
    wait_until_drained();
    push_random_until(ITEM_TARGET);
    wait_until_drained();

    if (error_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule
